/* design/slp_pkg.sv */
// slp_pkg: types, constants and the microcode store of the slew-limited servo PWM block.
// No dependencies; imported by slp_useq, slp_datapath, the top level and the testbench.
`default_nettype none

package slp_pkg;

   // channel count and field widths
   localparam int CHANNELS    = 6;
   localparam int CH_W        = 3;
   localparam int REF_W       = 12;
   localparam int VEL_W       = 10;
   localparam int PIN_W       = 6;
   localparam int PWM_W       = 14;
   localparam int CFG_W       = 12;
   localparam int POS_W       = 19;
   localparam int DW_W        = POS_W + 1;
   localparam int CSR_IDX_W   = 2;
   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 24;
   localparam int RSP_PAD_W   = RSP_TDATA_W - CH_W - PWM_W;

   // arithmetic constants
   localparam int HUNDRED     = 100;
   // pos/100 = (|pos| * RECIP_K) >> RECIP_SH, exact for |pos| < 2**18
   localparam int RECIP_SH    = 25;
   localparam int RECIP_W     = 19;
   localparam int RECIP_K     = ((1 << RECIP_SH) + HUNDRED - 1) / HUNDRED;
   localparam int Q_W         = 13;
   localparam int SCALED_W    = Q_W + CFG_W;
   localparam int DIV_SH      = 10;
   localparam int SMAG_W      = SCALED_W - DIV_SH;
   localparam int SUM_W       = SMAG_W + 2;
   localparam int PWM_MAX     = (1 << PWM_W) - 1;

   localparam logic [CFG_W-1:0] PULSE_RST  = CFG_W'(1638);
   localparam logic [CFG_W-1:0] CENTER_RST = CFG_W'(1638);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_PULSE  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_CENTER = CSR_IDX_W'(1);

   // microprogram
   localparam int PC_W = 4;

   typedef enum logic [3:0] {
      OP_WAIT,
      OP_EVAL,
      OP_DELTA,
      OP_RECIP,
      OP_SCALE,
      OP_COMPOSE,
      OP_EMIT,
      OP_ADV,
      OP_FLUSH
   } op_type;

   typedef enum logic [2:0] {
      C_NEXT,
      C_ALWAYS,
      C_SET,
      C_DISABLE,
      C_STILL,
      C_MORE
   } cond_type;

   typedef struct packed {
      op_type              op;
      cond_type            cond;
      logic [PC_W-1:0]     target;
   } uword_type;

   typedef struct packed {
      op_type op;
      logic   go;
   } exec_type;

   typedef struct packed {
      logic req_vld;
      logic is_set;
      logic disable_evt;
      logic still;
      logic more;
      logic hold_vld;
      logic out_free;
   } sts_type;

   typedef struct packed {
      logic [CH_W-1:0]  ch;
      logic [PWM_W-1:0] value;
      logic             disabled;
   } result_type;

   localparam logic [PC_W-1:0] A_WAIT    = PC_W'(0);
   localparam logic [PC_W-1:0] A_EVAL    = PC_W'(1);
   localparam logic [PC_W-1:0] A_DELTA   = PC_W'(2);
   localparam logic [PC_W-1:0] A_RECIP   = PC_W'(3);
   localparam logic [PC_W-1:0] A_SCALE   = PC_W'(4);
   localparam logic [PC_W-1:0] A_COMPOSE = PC_W'(5);
   localparam logic [PC_W-1:0] A_EMIT    = PC_W'(6);
   localparam logic [PC_W-1:0] A_ADV     = PC_W'(7);
   localparam logic [PC_W-1:0] A_FLUSH   = PC_W'(8);

   // next address = cond true ? target : pc + 1
   function automatic uword_type ucode_rom(input logic [PC_W-1:0] addr);
      uword_type w;
      case (addr)
         A_WAIT:    w = '{op: OP_WAIT,    cond: C_SET,     target: A_WAIT};
         A_EVAL:    w = '{op: OP_EVAL,    cond: C_DISABLE, target: A_EMIT};
         A_DELTA:   w = '{op: OP_DELTA,   cond: C_STILL,   target: A_ADV};
         A_RECIP:   w = '{op: OP_RECIP,   cond: C_NEXT,    target: A_WAIT};
         A_SCALE:   w = '{op: OP_SCALE,   cond: C_NEXT,    target: A_WAIT};
         A_COMPOSE: w = '{op: OP_COMPOSE, cond: C_NEXT,    target: A_WAIT};
         A_EMIT:    w = '{op: OP_EMIT,    cond: C_NEXT,    target: A_WAIT};
         A_ADV:     w = '{op: OP_ADV,     cond: C_MORE,    target: A_EVAL};
         A_FLUSH:   w = '{op: OP_FLUSH,   cond: C_ALWAYS,  target: A_WAIT};
         default:   w = '{op: OP_WAIT,    cond: C_ALWAYS,  target: A_WAIT};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

/* design/slew_limited_servo_pwm_top.sv */
// slew_limited_servo_pwm_top: six-channel slew-limited servo PWM controller, top level.
// Depends on slp_pkg, slp_useq and slp_datapath.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------------
//  req_    | in        | req_tvalid/tready  | set (tuser 0) or tick (tuser 1) transaction
//  rsp_    | out       | rsp_tvalid/tready  | one compare-value write per acting channel
//  csr_    | in        | csr_valid/ready    | register write: 0 pulse counts, 1 centre
//
// Set transaction: handled at the idle step, taken back to back.
// Tick transaction: idle step, then per channel eval, delta, adv (no move), eval, emit, adv
//   (switch-off) or eval, delta, recip, scale, compose, emit, adv (move), then a flush step.
// A stalled rsp_ side holds the sequencer at its emit or flush step; req_ is taken only idle.
// Reset (synchronous) clears all channel state and loads both registers with 1638.
`default_nettype none

module slew_limited_servo_pwm_top (
   input  logic                             clock,
   input  logic                             reset,
   // slave side
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [2:0] channel, [14:3] reference, [15] enable_request, [25:16] velocity,
   // [31:26] pin_low_mask
   input  logic [slp_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // [0] action
   input  logic                             req_tuser,
   // master side
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [2:0] out_channel, [16:3] pwm_value, [23:17] zero
   output logic [slp_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // [0] disabled
   output logic                             rsp_tuser,
   output logic                             rsp_tlast,
   // register writes
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [slp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [slp_pkg::CFG_W-1:0]        csr_data
);
   import slp_pkg::*;

   exec_type exec;
   sts_type  sts;

   // sequencer: control store and step counter
   slp_useq u_useq (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .exec  (exec)
   );

   // datapath: channel state, arithmetic and output stage
   slp_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .exec       (exec),
      .sts        (sts),
      .req_tvalid (req_tvalid),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // a transaction is taken only while the sequencer sits at its idle step
   assign req_tready = exec.op == OP_WAIT;
   // registers take a write in any cycle
   assign csr_ready  = 1'b1;

endmodule

`default_nettype wire

/* design/slp_useq.sv */
// slp_useq: microcode sequencer - step counter, control store lookup, stalls and jumps.
// Depends on slp_pkg.
`default_nettype none

module slp_useq (
   input  logic             clock,
   input  logic             reset,
   input  slp_pkg::sts_type sts,
   output slp_pkg::exec_type exec
);
   import slp_pkg::*;

   logic [PC_W-1:0] pc_ff, pc_in;
   uword_type       uword;
   logic            stall;
   logic            take;

   always_comb begin
      uword = ucode_rom(pc_ff);
      case (uword.op)
         OP_WAIT:  stall = !sts.req_vld;
         OP_EMIT:  stall = sts.hold_vld && !sts.out_free;
         OP_FLUSH: stall = sts.hold_vld && !sts.out_free;
         default:  stall = 1'b0;
      endcase
      case (uword.cond)
         C_NEXT:    take = 1'b0;
         C_ALWAYS:  take = 1'b1;
         C_SET:     take = sts.is_set;
         C_DISABLE: take = sts.disable_evt;
         C_STILL:   take = sts.still;
         C_MORE:    take = sts.more;
         default:   take = 1'b0;
      endcase
      pc_in = pc_ff;
      if (!stall) begin
         pc_in = take ? uword.target : pc_ff + 1'b1;
      end
      exec.op = uword.op;
      exec.go = !stall;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= A_WAIT;
      end else begin
         pc_ff <= pc_in;
      end
   end

   // step counter stays inside the program
   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      pc_ff <= A_FLUSH) else $error("step counter left the program");

   // nothing may be held back while a new transaction can be taken
   a_idle_flushed: assert property (@(posedge clock) disable iff (reset)
      exec.op == OP_WAIT |-> !sts.hold_vld) else $error("held result at idle");

   // flush always returns to idle
   a_flush_ret: assert property (@(posedge clock) disable iff (reset)
      exec.go && exec.op == OP_FLUSH |=> exec.op == OP_WAIT)
      else $error("flush did not return to idle");

endmodule

`default_nettype wire

/* design/slp_datapath.sv */
// slp_datapath: channel state, slew step, compare-value arithmetic, result hold and output register.
// Depends on slp_pkg; steered by slp_useq.
`default_nettype none

module slp_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  slp_pkg::exec_type                exec,
   output slp_pkg::sts_type                 sts,
   input  logic                             req_tvalid,
   input  logic [slp_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  logic                             req_tuser,
   input  logic                             csr_valid,
   input  logic [slp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [slp_pkg::CFG_W-1:0]        csr_data,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [slp_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output logic                             rsp_tuser,
   output logic                             rsp_tlast
);
   import slp_pkg::*;

   // request fields
   logic [CH_W-1:0]         req_ch;
   logic signed [REF_W-1:0] req_ref;
   logic                    req_en;
   logic [VEL_W-1:0]        req_vel;
   logic [PIN_W-1:0]        req_pins;

   assign req_ch   = req_tdata[CH_W-1:0];
   assign req_ref  = req_tdata[CH_W+REF_W-1:CH_W];
   assign req_en   = req_tdata[CH_W+REF_W];
   assign req_vel  = req_tdata[CH_W+REF_W+VEL_W:CH_W+REF_W+1];
   assign req_pins = req_tdata[CH_W+REF_W+VEL_W+PIN_W:CH_W+REF_W+VEL_W+1];

   // configuration
   logic [CFG_W-1:0] pulse_ff, pulse_in, center_ff, center_in;

   // per-channel state
   logic [CHANNELS-1:0]     enabled_ff, enabled_in, wanted_ff, wanted_in;
   logic signed [REF_W-1:0] target_ff [CHANNELS];
   logic signed [REF_W-1:0] target_in [CHANNELS];
   logic [VEL_W-1:0]        slew_ff [CHANNELS];
   logic [VEL_W-1:0]        slew_in [CHANNELS];
   logic signed [POS_W-1:0] pos_ff [CHANNELS];
   logic signed [POS_W-1:0] pos_in [CHANNELS];

   // walk registers
   logic [CH_W-1:0]         ch_ff, ch_in;
   logic [PIN_W-1:0]        pins_ff, pins_in;
   logic                    en_now_ff, en_now_in;
   logic signed [POS_W-1:0] tgt_scaled_ff, tgt_scaled_in;
   logic signed [POS_W-1:0] newpos_ff, newpos_in;
   logic [Q_W-1:0]          q_ff, q_in;
   logic                    neg_ff, neg_in;
   logic [SCALED_W-1:0]     scaled_ff, scaled_in;
   result_type              new_res_ff, new_res_in;
   result_type              hold_ff, hold_in;
   logic                    hold_vld_ff, hold_vld_in;
   result_type              rsp_res_ff, rsp_res_in;
   logic                    rsp_vld_ff, rsp_vld_in;
   logic                    rsp_last_ff, rsp_last_in;

   // combinational
   logic                    cur_en, cur_wt, pin_low, en_next, disable_evt;
   logic signed [POS_W-1:0] pos_cur;
   logic [VEL_W-1:0]        lim;
   logic signed [DW_W-1:0]  dw, mag, step;
   logic                    moved;
   logic signed [POS_W-1:0] new_pos;
   logic [RECIP_W-1:0]      newpos_mag;
   logic [RECIP_W+RECIP_W-1:0] recip_prod;
   logic [SMAG_W-1:0]       smag;
   logic signed [SUM_W-1:0] sval;
   logic [PWM_W-1:0]        pwm_sat;
   logic                    out_free;

   assign out_free = !rsp_vld_ff || rsp_tready;

   always_comb begin
      cur_en      = enabled_ff[ch_ff];
      cur_wt      = wanted_ff[ch_ff];
      pin_low     = (ch_ff < CH_W'(PIN_W)) ? pins_ff[ch_ff] : 1'b0;
      en_next     = cur_wt | (cur_en & ~pin_low);
      disable_evt = cur_en & ~cur_wt & pin_low;

      // slew step toward target*100
      pos_cur = pos_ff[ch_ff];
      lim     = slew_ff[ch_ff];
      dw      = DW_W'(tgt_scaled_ff) - DW_W'(pos_cur);
      mag     = dw[DW_W-1] ? -dw : dw;
      step    = dw;
      if (lim != '0 && mag > $signed({{(DW_W-VEL_W){1'b0}}, lim})) begin
         step = dw[DW_W-1] ? -$signed({{(DW_W-VEL_W){1'b0}}, lim})
                           :  $signed({{(DW_W-VEL_W){1'b0}}, lim});
      end
      moved   = en_now_ff && (dw != '0);
      new_pos = pos_cur + step[POS_W-1:0];

      // |pos|/100 by reciprocal
      newpos_mag = newpos_ff[POS_W-1] ? RECIP_W'(-newpos_ff) : RECIP_W'(newpos_ff);
      recip_prod = newpos_mag * (RECIP_W+RECIP_W)'(RECIP_K);

      // truncation toward zero on the magnitude, then centre and clamp
      smag = scaled_ff[SCALED_W-1:DIV_SH];
      sval = neg_ff ? -$signed({2'b00, smag}) : $signed({2'b00, smag});
      sval = sval + $signed({{(SUM_W-CFG_W){1'b0}}, center_ff});
      if (sval < 0) begin
         pwm_sat = '0;
      end else if (sval > SUM_W'(PWM_MAX)) begin
         pwm_sat = PWM_W'(PWM_MAX);
      end else begin
         pwm_sat = sval[PWM_W-1:0];
      end
   end

   // next-state
   always_comb begin
      pulse_in      = pulse_ff;
      center_in     = center_ff;
      enabled_in    = enabled_ff;
      wanted_in     = wanted_ff;
      target_in     = target_ff;
      slew_in       = slew_ff;
      pos_in        = pos_ff;
      ch_in         = ch_ff;
      pins_in       = pins_ff;
      en_now_in     = en_now_ff;
      tgt_scaled_in = tgt_scaled_ff;
      newpos_in     = newpos_ff;
      q_in          = q_ff;
      neg_in        = neg_ff;
      scaled_in     = scaled_ff;
      new_res_in    = new_res_ff;
      hold_in       = hold_ff;
      hold_vld_in   = hold_vld_ff;
      rsp_res_in    = rsp_res_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_vld_in    = rsp_vld_ff && !rsp_tready;

      if (csr_valid) begin
         if (csr_index == REG_PULSE) begin
            pulse_in = csr_data;
         end else if (csr_index == REG_CENTER) begin
            center_in = csr_data;
         end
      end

      if (exec.go) begin
         case (exec.op)
            OP_WAIT: begin
               if (!req_tuser) begin
                  if (req_ch < CH_W'(CHANNELS)) begin
                     target_in[req_ch] = req_ref;
                     wanted_in[req_ch] = req_en;
                     slew_in[req_ch]   = req_vel;
                  end
               end else begin
                  ch_in   = '0;
                  pins_in = req_pins;
               end
            end
            OP_EVAL: begin
               enabled_in[ch_ff] = en_next;
               en_now_in         = en_next;
               tgt_scaled_in     = POS_W'(target_ff[ch_ff] * $signed(POS_W'(HUNDRED)));
               if (disable_evt) begin
                  new_res_in = '{ch: ch_ff, value: '0, disabled: 1'b1};
               end
            end
            OP_DELTA: begin
               newpos_in = new_pos;
               if (moved) begin
                  pos_in[ch_ff] = new_pos;
               end
            end
            OP_RECIP: begin
               q_in   = recip_prod[RECIP_SH+Q_W-1:RECIP_SH];
               neg_in = newpos_ff[POS_W-1];
            end
            OP_SCALE: begin
               scaled_in = q_ff * SCALED_W'(pulse_ff);
            end
            OP_COMPOSE: begin
               new_res_in = '{ch: ch_ff, value: pwm_sat, disabled: 1'b0};
            end
            OP_EMIT: begin
               if (hold_vld_ff) begin
                  rsp_res_in  = hold_ff;
                  rsp_last_in = 1'b0;
                  rsp_vld_in  = 1'b1;
               end
               hold_in     = new_res_ff;
               hold_vld_in = 1'b1;
            end
            OP_ADV: begin
               ch_in = ch_ff + 1'b1;
            end
            OP_FLUSH: begin
               if (hold_vld_ff) begin
                  rsp_res_in  = hold_ff;
                  rsp_last_in = 1'b1;
                  rsp_vld_in  = 1'b1;
               end
               hold_vld_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_ff    <= PULSE_RST;
         center_ff   <= CENTER_RST;
         enabled_ff  <= '0;
         wanted_ff   <= '0;
         for (int i = 0; i < CHANNELS; i++) begin
            target_ff[i] <= '0;
            slew_ff[i]   <= '0;
            pos_ff[i]    <= '0;
         end
         hold_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         pulse_ff    <= pulse_in;
         center_ff   <= center_in;
         enabled_ff  <= enabled_in;
         wanted_ff   <= wanted_in;
         target_ff   <= target_in;
         slew_ff     <= slew_in;
         pos_ff      <= pos_in;
         hold_vld_ff <= hold_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff         <= ch_in;
      pins_ff       <= pins_in;
      en_now_ff     <= en_now_in;
      tgt_scaled_ff <= tgt_scaled_in;
      newpos_ff     <= newpos_in;
      q_ff          <= q_in;
      neg_ff        <= neg_in;
      scaled_ff     <= scaled_in;
      new_res_ff    <= new_res_in;
      hold_ff       <= hold_in;
      rsp_res_ff    <= rsp_res_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign sts.req_vld     = req_tvalid;
   assign sts.is_set      = !req_tuser;
   assign sts.disable_evt = disable_evt;
   assign sts.still       = !moved;
   assign sts.more        = ch_ff != CH_W'(CHANNELS - 1);
   assign sts.hold_vld    = hold_vld_ff;
   assign sts.out_free    = out_free;

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_res_ff.value, rsp_res_ff.ch};
   assign rsp_tuser  = rsp_res_ff.disabled;
   assign rsp_tlast  = rsp_last_ff;

   // a held result is only pushed into a free output register
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      exec.go && exec.op == OP_EMIT && hold_vld_ff |-> out_free)
      else $error("output overwritten");

   // switch-off transactions drive zero
   a_off_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_res_ff.disabled |-> rsp_res_ff.value == '0)
      else $error("switch-off with nonzero value");

   // results only name existing channels
   a_ch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> rsp_res_ff.ch < CH_W'(CHANNELS))
      else $error("result channel out of range");

endmodule

`default_nettype wire

/* tb/slew_limited_servo_pwm_top_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for slew_limited_servo_pwm_top: queued set/tick stimulus,
// a transaction-level servo predictor and an in-order check of every compare-value write.
// Depends on slp_pkg and the design sources only.

module slew_limited_servo_pwm_top_test;
   import slp_pkg::*;

   // action codes carried on req_tuser
   localparam logic ACT_SET  = 1'b0;
   localparam logic ACT_TICK = 1'b1;
   // register indexes the block does not decode; writes there must change nothing
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_A = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_B = CSR_IDX_W'(3);

   localparam int SETTLE_CYCLES = 100;  // > one full tick plus flush under stall
   localparam int LONG_HOLD     = 400;  // result side held off this long once
   localparam int PRINT_CAP     = 40;

   typedef struct {
      logic                    action;
      logic [CH_W-1:0]         channel;
      logic signed [REF_W-1:0] reference;
      logic                    enable_req;
      logic [VEL_W-1:0]        velocity;
      logic [PIN_W-1:0]        pin_low;
   } servo_item_type;

   typedef struct {
      logic [CH_W-1:0]  ch;
      logic [PWM_W-1:0] value;
      logic             disabled;
      logic             last;
   } pwm_write_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   req_tuser  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index  = '0;
   logic [CFG_W-1:0]       csr_data   = '0;

   slew_limited_servo_pwm_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------------------------
   // Predictor state: a private copy of the channel registers and the two settings.
   // ---------------------------------------------------------------------------------
   logic [CFG_W-1:0]        pulse_cfg  = PULSE_RST;
   logic [CFG_W-1:0]        center_cfg = CENTER_RST;
   logic                    ch_enabled [CHANNELS];
   logic                    ch_wanted  [CHANNELS];
   logic signed [REF_W-1:0] ch_target  [CHANNELS];
   logic [VEL_W-1:0]        ch_slew    [CHANNELS];
   logic signed [POS_W-1:0] ch_pos     [CHANNELS];

   initial begin
      for (int i = 0; i < CHANNELS; i++) begin
         ch_enabled[i] = 1'b0;
         ch_wanted[i]  = 1'b0;
         ch_target[i]  = '0;
         ch_slew[i]    = '0;
         ch_pos[i]     = '0;
      end
   end

   servo_item_type pending_items [$];   // filled by the sequence, drained by the driver
   pwm_write_type  writes_due    [$];   // predicted compare writes, oldest first

   int items_queued   = 0;
   int items_accepted = 0;
   int sets_taken     = 0;
   int ticks_taken    = 0;
   int writes_seen    = 0;
   int offs_seen      = 0;
   int csr_writes     = 0;
   int mismatches     = 0;

   int idle_pct    = 25;   // odds of starting an idle burst, per transaction / ready cycle
   bit pressure_on = 1'b0;
   int hold_cycles = 0;

   task automatic flag_mismatch(input string what);
      mismatches++;
      if (mismatches <= PRINT_CAP)
         $display("MISMATCH at %0t ns: %s", $time, what);
   endtask

   // Compare value for a hundredths position: both divisions truncate toward zero
   // (SystemVerilog int division does this), then clamp to the 14-bit field.
   function automatic logic [PWM_W-1:0] pwm_of(input int pos);
      int v;
      v = ((pos / HUNDRED) * int'(pulse_cfg)) / (1 << DIV_SH) + int'(center_cfg);
      if (v < 0)
         v = 0;
      if (v > PWM_MAX)
         v = PWM_MAX;
      return PWM_W'(v);
   endfunction

   // Advance the predictor by one accepted request and queue the writes it causes.
   function automatic void servo_step(input servo_item_type it);
      pwm_write_type batch [$];
      pwm_write_type w;
      int            dw;
      int            lim;
      int            mag;
      if (it.action == ACT_SET) begin
         sets_taken++;
         // channels 6 and 7 do not exist: the set is dropped
         if (int'(it.channel) < CHANNELS) begin
            ch_target[it.channel] = it.reference;
            ch_wanted[it.channel] = it.enable_req;
            ch_slew[it.channel]   = it.velocity;
         end
         return;
      end
      ticks_taken++;
      for (int i = 0; i < CHANNELS; i++) begin
         if (ch_enabled[i] != ch_wanted[i]) begin
            if (!ch_wanted[i]) begin
               // switch-off waits for the pin to read low; until then it keeps driving
               if (it.pin_low[i]) begin
                  ch_enabled[i] = 1'b0;
                  w.ch       = CH_W'(i);
                  w.value    = '0;
                  w.disabled = 1'b1;
                  w.last     = 1'b0;
                  batch.push_back(w);
               end
            end else begin
               ch_enabled[i] = 1'b1;
            end
         end
         if (ch_enabled[i]) begin
            dw  = int'(ch_target[i]) * HUNDRED - int'(ch_pos[i]);
            lim = int'(ch_slew[i]);
            mag = (dw < 0) ? -dw : dw;
            if (lim > 0 && mag > lim)
               dw = (dw > 0) ? lim : -lim;
            if (dw != 0) begin
               ch_pos[i]  = POS_W'(int'(ch_pos[i]) + dw);
               w.ch       = CH_W'(i);
               w.value    = pwm_of(int'(ch_pos[i]));
               w.disabled = 1'b0;
               w.last     = 1'b0;
               batch.push_back(w);
            end
         end
      end
      if (batch.size() > 0)
         batch[batch.size() - 1].last = 1'b1;
      foreach (batch[k])
         writes_due.push_back(batch[k]);
   endfunction

   // ---------------------------------------------------------------------------------
   // Request driver: offers queued items, holds each until taken, idles in bursts.
   // The predictor runs at the edge where the transaction is accepted.
   // ---------------------------------------------------------------------------------
   servo_item_type in_flight;
   int             gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            servo_step(in_flight);
            items_accepted++;
         end
         if (req_tvalid && !req_tready) begin
            // still waiting: keep the same transaction on the bus
         end else if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_items.size() > 0) begin
            in_flight = pending_items.pop_front();
            req_tdata <= {in_flight.pin_low, in_flight.velocity, in_flight.enable_req,
                          in_flight.reference, in_flight.channel};
            req_tuser  <= in_flight.action;
            req_tvalid <= 1'b1;
            if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
               gap_left = $urandom_range(1, 8);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Result monitor: random ready bursts, one long hold-off during the pressure phase,
   // and an in-order field check of every accepted write.
   // ---------------------------------------------------------------------------------
   int stall_left = 0;

   task automatic check_write();
      pwm_write_type    want;
      logic [CH_W-1:0]  got_ch;
      logic [PWM_W-1:0] got_val;
      got_ch  = rsp_tdata[CH_W-1:0];
      got_val = rsp_tdata[CH_W +: PWM_W];
      writes_seen++;
      if (rsp_tuser)
         offs_seen++;
      if (writes_due.size() == 0) begin
         flag_mismatch($sformatf("unexpected write: ch %0d value %0d off %0b last %0b",
                                 got_ch, got_val, rsp_tuser, rsp_tlast));
      end else begin
         want = writes_due.pop_front();
         if (got_ch !== want.ch || got_val !== want.value ||
             rsp_tuser !== want.disabled || rsp_tlast !== want.last)
            flag_mismatch($sformatf(
               "write got ch %0d value %0d off %0b last %0b, want %0d %0d %0b %0b",
               got_ch, got_val, rsp_tuser, rsp_tlast,
               want.ch, want.value, want.disabled, want.last));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            check_write();
         if (pressure_on && hold_cycles < LONG_HOLD) begin
            hold_cycles++;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
               stall_left = $urandom_range(1, 8);
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------------
   task automatic queue_set(input int ch, input int refv, input bit en, input int vel);
      servo_item_type it;
      it.action     = ACT_SET;
      it.channel    = CH_W'(ch);
      it.reference  = REF_W'(refv);
      it.enable_req = en;
      it.velocity   = VEL_W'(vel);
      it.pin_low    = PIN_W'($urandom);   // ignored on a set
      pending_items.push_back(it);
      items_queued++;
   endtask

   task automatic queue_tick(input logic [PIN_W-1:0] mask);
      servo_item_type it;
      it.action     = ACT_TICK;
      it.channel    = CH_W'($urandom);    // the rest is ignored on a tick
      it.reference  = REF_W'($urandom);
      it.enable_req = 1'($urandom_range(0, 1));
      it.velocity   = VEL_W'($urandom);
      it.pin_low    = mask;
      pending_items.push_back(it);
      items_queued++;
   endtask

   // Random mix: mostly sets to real channels with lively targets, ticks with random pins.
   task automatic queue_random(input int n);
      servo_item_type it;
      int             r;
      repeat (n) begin
         it.action  = ($urandom_range(0, 99) < 45) ? ACT_TICK : ACT_SET;
         it.channel = ($urandom_range(0, 9) == 0) ? CH_W'($urandom_range(6, 7))
                                                 : CH_W'($urandom_range(0, CHANNELS - 1));
         case ($urandom_range(0, 3))
            0: r = int'($urandom_range(0, 4095)) - 2048;
            1: r = int'($urandom_range(0, 40)) - 20;
            2: r = ($urandom_range(0, 1) != 0) ? 2047 : -2048;
            default: r = int'($urandom_range(0, 2048)) - 512;
         endcase
         it.reference  = REF_W'(r);
         it.enable_req = ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 3))
            0: it.velocity = '0;
            1: it.velocity = VEL_W'($urandom_range(1, 50));
            default: it.velocity = VEL_W'($urandom);
         endcase
         case ($urandom_range(0, 5))
            0: it.pin_low = '0;
            1: it.pin_low = '1;
            default: it.pin_low = PIN_W'($urandom);
         endcase
         pending_items.push_back(it);
         items_queued++;
      end
   endtask

   // Wait until every queued item is taken and every predicted write has arrived,
   // then let a tick that emits nothing more run out.
   task automatic settle();
      while (items_accepted != items_queued || writes_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
      @(posedge clock);
      csr_index <= idx;
      csr_data  <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      csr_writes++;
      if (idx == REG_PULSE)
         pulse_cfg = val;
      else if (idx == REG_CENTER)
         center_cfg = val;
   endtask

   // ---------------------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------------------
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed, reset settings
      queue_tick('1);                  // nothing enabled: tick yields no write
      queue_set(0, 2047, 1'b1, 0);     // no slew limit: jump to the top
      queue_set(1, -2048, 1'b1, 1023); // widest limited step, bottom target
      queue_set(2, 0, 1'b1, 1);        // enabled at its target: no move
      queue_set(3, 1, 1'b1, 100);      // distance equals the limit exactly
      queue_set(5, 1000, 1'b1, 500);
      queue_set(6, 5, 1'b1, 3);        // channels past the end are dropped
      queue_set(7, -5, 1'b1, 3);
      queue_tick('0);
      queue_tick(6'h15);
      queue_set(0, 100, 1'b0, 0);      // release with pin high: keeps moving
      queue_set(4, -1, 1'b0, 0);       // release of a channel never enabled
      queue_tick(6'h3E);
      queue_tick('1);                  // pin low: channel 0 switches off
      queue_set(1, -2048, 1'b0, 1023);
      queue_tick(6'h01);               // channel 1 pin high: still moving
      queue_set(0, 2047, 1'b1, 0);     // re-enable takes effect at once
      queue_tick('0);
      queue_tick('1);
      settle();

      // extreme scaling with no centre: negative positions clamp at zero
      write_reg(REG_PULSE, '1);
      write_reg(REG_CENTER, '0);
      write_reg(REG_SPARE_A, '1);
      write_reg(REG_SPARE_B, 12'h5A5);
      queue_set(2, -2048, 1'b1, 0);
      queue_tick('0);
      queue_random(50);
      settle();

      // zero scaling, full centre; result side held off while ticks keep coming
      write_reg(REG_PULSE, '0);
      write_reg(REG_CENTER, '1);
      idle_pct    = 10;
      pressure_on = 1'b1;
      for (int i = 0; i < CHANNELS; i++)
         queue_set(i, (i % 2 != 0) ? -2000 : 2000, 1'b1, i + 1);
      repeat (30) queue_tick('0);
      queue_random(10);
      settle();

      // both settings at the top
      write_reg(REG_PULSE, '1);
      write_reg(REG_CENTER, '1);
      idle_pct = 40;
      queue_random(50);
      settle();

      // random settings, no idling on either side
      write_reg(REG_PULSE, CFG_W'($urandom));
      write_reg(REG_CENTER, CFG_W'($urandom));
      idle_pct = 0;
      queue_random(50);
      settle();

      while (writes_due.size() != 0) begin
         flag_mismatch("expected write never arrived");
         void'(writes_due.pop_front());
      end

      $display("covered %0d set and %0d tick transactions, %0d writes (%0d switch-offs)",
               sets_taken, ticks_taken, writes_seen, offs_seen);
      $display("with %0d register writes and a %0d-cycle result hold-off",
               csr_writes, hold_cycles);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #2000000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
